@@ design/cubic_bezier_easing_unit_macros.svh @@
// ----------------------------------------------------------------------------
// cubic bezier easing unit assertion macros
// shared concurrent assertion forms used by cubic_bezier_easing_unit.sv
// ----------------------------------------------------------------------------
`ifndef CUBIC_BEZIER_EASING_UNIT_MACROS_SVH
`define CUBIC_BEZIER_EASING_UNIT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define CBE_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("cbe assertion failed");

// property that must hold in the cycle after its trigger
`define CBE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cbe assertion failed");

`endif

@@ design/cbe_pkg.sv @@
// ----------------------------------------------------------------------------
// cbe_pkg
// widths, constants and stage payload type of the cubic bezier easing unit
// ----------------------------------------------------------------------------
package cbe_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int ITERATIONS = 30;
   localparam int E_BITS     = 30;
   localparam int T_BITS     = 33;

   localparam int DATA_W  = 18;
   localparam int CX_W    = 17;
   localparam int IDX_W   = 8;
   localparam int TQ_W    = E_BITS + 1;
   localparam int COEF_W  = DATA_W + 1;
   localparam int K_W     = TQ_W + 2;
   localparam int PROD_W  = K_W + 1 + COEF_W;
   localparam int SH_W    = PROD_W - FRAC_BITS;
   localparam int VAL_W   = SH_W + 2;

   // register indexes
   localparam logic [IDX_W-1:0] REG_CTRL_X1 = IDX_W'(0);
   localparam logic [IDX_W-1:0] REG_CTRL_Y1 = IDX_W'(1);
   localparam logic [IDX_W-1:0] REG_CTRL_X2 = IDX_W'(2);
   localparam logic [IDX_W-1:0] REG_CTRL_Y2 = IDX_W'(3);

   // reset values
   localparam logic [CX_W-1:0]   RST_X1 = CX_W'((1 << FRAC_BITS) / 4);
   localparam logic [DATA_W-1:0] RST_Y1 = DATA_W'(((1 << FRAC_BITS) + 5) / 10);
   localparam logic [CX_W-1:0]   RST_X2 = CX_W'((1 << FRAC_BITS) / 4);
   localparam logic [DATA_W-1:0] RST_Y2 = DATA_W'(1 << FRAC_BITS);

   // payload carried alongside the polynomial pipeline
   typedef struct packed {
      logic                  clamp;
      logic [DATA_W-1:0]     clamp_val;
      logic [E_BITS-1:0]     x30;
      logic [T_BITS:0]       lo;
      logic [T_BITS:0]       hi;
      logic [T_BITS:0]       mid;
   } ctl_type;

endpackage

@@ design/cbe_if.sv @@
// ----------------------------------------------------------------------------
// cbe channel interfaces
// valid/ready channels for progress, eased value and register writes
// ----------------------------------------------------------------------------
interface cbe_req_if;
   import cbe_pkg::*;
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] progress;
   modport source (output valid, output progress, input ready);
   modport sink   (input valid, input progress, output ready);
endinterface

interface cbe_rsp_if;
   import cbe_pkg::*;
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] eased;
   modport source (output valid, output eased, input ready);
   modport sink   (input valid, input eased, output ready);
endinterface

interface cbe_csr_if;
   import cbe_pkg::*;
   logic              valid;
   logic              ready;
   logic [IDX_W-1:0]  index;
   logic [DATA_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

@@ design/cbe_poly.sv @@
// ----------------------------------------------------------------------------
// cbe_poly
// four-stage evaluator of 3(1-t)^2 t a + 3(1-t) t^2 b + t^3 in Q30
// ----------------------------------------------------------------------------
module cbe_poly import cbe_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     adv,
   input  logic                     in_vld,
   input  ctl_type                  in_ctl,
   input  logic [TQ_W-1:0]          in_tq,
   input  logic signed [COEF_W-1:0] coef_a,
   input  logic signed [COEF_W-1:0] coef_b,
   output logic                     out_vld,
   output ctl_type                  out_ctl,
   output logic signed [VAL_W-1:0]  out_val
);

   localparam logic [TQ_W-1:0] ONE_E = TQ_W'(1) << E_BITS;

   logic [3:0]   vld_ff;
   ctl_type      ctl1_ff, ctl2_ff, ctl3_ff, ctl4_ff;

   // stage 1: squares of w and t
   logic [TQ_W-1:0]   w_in;
   logic [2*TQ_W-1:0] ww_prod, tt_prod;
   logic [TQ_W-1:0]   s1_w_ff, s1_tq_ff, s1_w2_ff, s1_t2_ff;

   assign w_in    = ONE_E - in_tq;
   assign ww_prod = w_in * w_in;
   assign tt_prod = in_tq * in_tq;

   // stage 2: cubic terms
   logic [2*TQ_W-1:0] t3_prod, m1_prod, m2_prod;
   logic [TQ_W-1:0]   s2_t3_ff, s2_m1_ff, s2_m2_ff;

   assign t3_prod = s1_t2_ff * s1_tq_ff;
   assign m1_prod = s1_w2_ff * s1_tq_ff;
   assign m2_prod = s1_w_ff * s1_t2_ff;

   // stage 3: weight by control coordinates
   logic [K_W-1:0]           k1, k2;
   logic signed [PROD_W-1:0] p1_in, p2_in;
   logic signed [PROD_W-1:0] s3_p1_ff, s3_p2_ff;
   logic [TQ_W-1:0]          s3_t3_ff;

   assign k1    = {2'b00, s2_m1_ff} + {1'b0, s2_m1_ff, 1'b0};
   assign k2    = {2'b00, s2_m2_ff} + {1'b0, s2_m2_ff, 1'b0};
   assign p1_in = $signed({1'b0, k1}) * coef_a;
   assign p2_in = $signed({1'b0, k2}) * coef_b;

   // stage 4: floor shift and sum
   logic signed [SH_W-1:0]  q1, q2;
   logic signed [VAL_W-1:0] val_in, val_ff;

   assign q1     = s3_p1_ff[PROD_W-1:FRAC_BITS];
   assign q2     = s3_p2_ff[PROD_W-1:FRAC_BITS];
   assign val_in = VAL_W'(q1) + VAL_W'(q2) + VAL_W'($signed({1'b0, s3_t3_ff}));

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[2:0], in_vld};
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (adv) begin
         ctl1_ff  <= in_ctl;
         s1_w_ff  <= w_in;
         s1_tq_ff <= in_tq;
         s1_w2_ff <= ww_prod[E_BITS +: TQ_W];
         s1_t2_ff <= tt_prod[E_BITS +: TQ_W];
         ctl2_ff  <= ctl1_ff;
         s2_t3_ff <= t3_prod[E_BITS +: TQ_W];
         s2_m1_ff <= m1_prod[E_BITS +: TQ_W];
         s2_m2_ff <= m2_prod[E_BITS +: TQ_W];
         ctl3_ff  <= ctl2_ff;
         s3_p1_ff <= p1_in;
         s3_p2_ff <= p2_in;
         s3_t3_ff <= s2_t3_ff;
         ctl4_ff  <= ctl3_ff;
         val_ff   <= val_in;
      end
   end

   assign out_vld = vld_ff[3];
   assign out_ctl = ctl4_ff;
   assign out_val = val_ff;

endmodule

@@ design/cubic_bezier_easing_unit.sv @@
// ----------------------------------------------------------------------------
// cubic_bezier_easing_unit
// css style cubic bezier easing curve, progress in, eased value out, Q16
// ----------------------------------------------------------------------------
// usage:
//   req_if carries progress x (signed Q2.16), rsp_if returns eased y
//   (signed Q2.16, saturated to 18 bits). csr_if writes the control points:
//   index 0 x1, 1 y1, 2 x2, 3 y2; other indexes are ignored. csr_if is
//   always ready; write it only while no beat is in flight.
//   x at or below 0 gives 0, x at or above 1.0 gives 1.0, other values run
//   30 bisection steps on the curve parameter and then the y polynomial.
// pipeline and throughput:
//   a beat passes one entry stage, five stages per bisection step (four
//   for the x polynomial multipliers, one for the compare and interval
//   update), four for the y polynomial, one for rounding and saturation.
//   one beat per cycle is taken and returned unless the pipeline stalls.
// reset:
//   synchronous, clears all valid bits and loads the ease control points.
// stall:
//   while rsp_if.valid is high and rsp_if.ready low the whole pipeline holds
//   and req_if.ready is low; no beat is lost or repeated.
// ----------------------------------------------------------------------------
`include "cubic_bezier_easing_unit_macros.svh"

module cubic_bezier_easing_unit import cbe_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   cbe_req_if.sink   req_if,
   cbe_rsp_if.source rsp_if,
   cbe_csr_if.sink   csr_if
);

   localparam logic signed [DATA_W-1:0] ONE_Q = DATA_W'(1 << FRAC_BITS);
   localparam logic [T_BITS:0] T_ONE   = (T_BITS+1)'(1) << T_BITS;
   localparam logic [T_BITS:0] FIN_SPAN = (T_BITS+1)'(1) << (T_BITS - ITERATIONS);
   localparam int RSH = E_BITS - FRAC_BITS;
   localparam int R_W = VAL_W + 1 - RSH;
   localparam logic signed [R_W-1:0] OUT_MAX = R_W'((1 << (DATA_W-1)) - 1);
   localparam logic signed [R_W-1:0] OUT_MIN = -R_W'(1 << (DATA_W-1));

   logic adv;

   // control point registers
   logic [CX_W-1:0]   x1_ff, x2_ff;
   logic [DATA_W-1:0] y1_ff, y2_ff;
   logic signed [COEF_W-1:0] cx1, cx2, cy1, cy2;

   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         x1_ff <= RST_X1;
         y1_ff <= RST_Y1;
         x2_ff <= RST_X2;
         y2_ff <= RST_Y2;
      end else if (csr_if.valid) begin
         case (csr_if.index)
            REG_CTRL_X1: x1_ff <= csr_if.data[CX_W-1:0];
            REG_CTRL_Y1: y1_ff <= csr_if.data;
            REG_CTRL_X2: x2_ff <= csr_if.data[CX_W-1:0];
            REG_CTRL_Y2: y2_ff <= csr_if.data;
            default: ;
         endcase
      end
   end

   assign cx1 = $signed({2'b00, x1_ff});
   assign cx2 = $signed({2'b00, x2_ff});
   assign cy1 = $signed({y1_ff[DATA_W-1], y1_ff});
   assign cy2 = $signed({y2_ff[DATA_W-1], y2_ff});

   // pipeline advances unless a finished beat is waiting
   logic                     rsp_vld_ff;
   logic signed [DATA_W-1:0] rsp_val_ff;

   assign adv          = !rsp_vld_ff || rsp_if.ready;
   assign req_if.ready = adv;

   // entry stage: clamp decision and bisection start
   logic [ITERATIONS:0] stg_vld;
   logic [ITERATIONS:0] stg_vld_in;
   ctl_type             stg_ctl [ITERATIONS+1];
   ctl_type             stg_ctl_in [ITERATIONS+1];
   ctl_type             ent_in;
   logic                x_low, x_high;

   assign x_low  = (req_if.progress <= 0);
   assign x_high = (req_if.progress >= ONE_Q);

   always_comb begin
      ent_in.clamp     = x_low || x_high;
      ent_in.clamp_val = x_low ? '0 : ONE_Q;
      ent_in.x30       = {req_if.progress[FRAC_BITS-1:0], {RSH{1'b0}}};
      ent_in.lo        = '0;
      ent_in.hi        = T_ONE;
      ent_in.mid       = T_ONE >> 1;
   end

   assign stg_vld_in[0] = req_if.valid;
   assign stg_ctl_in[0] = ent_in;

   // stage valid bits and payload for all bisection steps
   always_ff @(posedge clock) begin
      if (reset) begin
         stg_vld <= '0;
      end else if (adv) begin
         stg_vld <= stg_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         stg_ctl <= stg_ctl_in;
      end
   end

   // bisection steps
   for (genvar g = 0; g < ITERATIONS; g++) begin : g_step
      logic                    p_vld;
      ctl_type                 p_ctl;
      logic signed [VAL_W-1:0] p_val;
      logic                    go_hi;
      logic [T_BITS+1:0]       span_sum;
      ctl_type                 nxt_in;

      cbe_poly u_poly (
         .clock   (clock),
         .reset   (reset),
         .adv     (adv),
         .in_vld  (stg_vld[g]),
         .in_ctl  (stg_ctl[g]),
         .in_tq   (stg_ctl[g].mid[T_BITS:T_BITS-E_BITS]),
         .coef_a  (cx1),
         .coef_b  (cx2),
         .out_vld (p_vld),
         .out_ctl (p_ctl),
         .out_val (p_val)
      );

      // compare and interval update
      assign go_hi = VAL_W'($signed({1'b0, p_ctl.x30})) < p_val;

      always_comb begin
         nxt_in = p_ctl;
         if (go_hi) begin
            nxt_in.hi = p_ctl.mid;
         end else begin
            nxt_in.lo = p_ctl.mid;
         end
         span_sum   = {1'b0, nxt_in.lo} + {1'b0, nxt_in.hi};
         nxt_in.mid = span_sum[T_BITS+1:1];
      end

      assign stg_vld_in[g+1] = p_vld;
      assign stg_ctl_in[g+1] = nxt_in;
   end

   // y polynomial at the final midpoint
   logic                    fin_vld;
   ctl_type                 fin_ctl;
   logic signed [VAL_W-1:0] fin_val;

   cbe_poly u_poly_y (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .in_vld  (stg_vld[ITERATIONS]),
      .in_ctl  (stg_ctl[ITERATIONS]),
      .in_tq   (stg_ctl[ITERATIONS].mid[T_BITS:T_BITS-E_BITS]),
      .coef_a  (cy1),
      .coef_b  (cy2),
      .out_vld (fin_vld),
      .out_ctl (fin_ctl),
      .out_val (fin_val)
   );

   // round to Q16 and saturate
   logic signed [VAL_W:0]    rnd_sum;
   logic signed [R_W-1:0]    rnd;
   logic signed [DATA_W-1:0] sat;

   assign rnd_sum = (VAL_W+1)'(fin_val) + (VAL_W+1)'(1 << (RSH - 1));
   assign rnd     = rnd_sum[VAL_W:RSH];

   always_comb begin
      if (rnd > OUT_MAX) begin
         sat = OUT_MAX[DATA_W-1:0];
      end else if (rnd < OUT_MIN) begin
         sat = OUT_MIN[DATA_W-1:0];
      end else begin
         sat = rnd[DATA_W-1:0];
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (adv) begin
         rsp_vld_ff <= fin_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_val_ff <= fin_ctl.clamp ? fin_ctl.clamp_val : sat;
      end
   end

   assign rsp_if.valid = rsp_vld_ff;
   assign rsp_if.eased = rsp_val_ff;

   // checks
   `CBE_ASSERT_ALWAYS(a_final_span, clock, reset,
      !stg_vld[ITERATIONS] ||
      ((stg_ctl[ITERATIONS].hi - stg_ctl[ITERATIONS].lo) == FIN_SPAN))
   `CBE_ASSERT_ALWAYS(a_mid_inside, clock, reset,
      !stg_vld[1] || ((stg_ctl[1].lo < stg_ctl[1].mid) && (stg_ctl[1].mid < stg_ctl[1].hi)))
   `CBE_ASSERT_NEXT(a_stall_holds, clock, reset, !adv, $stable(stg_vld))
   `CBE_ASSERT_NEXT(a_clamp_out, clock, reset, fin_vld && fin_ctl.clamp && adv,
      rsp_val_ff == $past(fin_ctl.clamp_val))

endmodule
